### src/periodic_job_dispatcher_defines.svh
// Assertion macros for the periodic job dispatcher.
// Used by the top level only; no other dependencies.
`ifndef PERIODIC_JOB_DISPATCHER_DEFINES_SVH
`define PERIODIC_JOB_DISPATCHER_DEFINES_SVH
// Implication checked at each clock edge, disabled in reset.
`define PJD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked at each clock edge, disabled in reset.
`define PJD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### src/pjd_pkg.sv
// Shared types and constants for the periodic job dispatcher.
// No dependencies.
`default_nettype none
package pjd_pkg;
	localparam int unsigned MAX_JOBS = 6;
	localparam logic [1:0] KIND_SERVICE = 2'd0;
	localparam logic [1:0] KIND_REQUEST = 2'd1;
	localparam logic [1:0] KIND_DONE    = 2'd2;
	localparam logic [1:0] KIND_CLEAR   = 2'd3;
	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_DRAIN = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;
	localparam logic [1:0] ECLS_OK   = 2'd0;
	localparam logic [1:0] ECLS_LINK = 2'd1;
	localparam logic [2:0] CFG_ENABLE = 3'd6;
	localparam logic [23:0] PERIOD0_RST = 24'd100;
	localparam logic [23:0] PERIOD1_RST = 24'd1000;
	localparam logic [23:0] PERIOD2_RST = 24'd1000;
	localparam logic [23:0] PERIOD3_RST = 24'd200;
	localparam logic [23:0] PERIOD4_RST = 24'd1000;
	localparam logic [23:0] PERIOD5_RST = 24'd60000;
	localparam logic [5:0]  ENABLE_RST  = 6'd39;

	typedef enum logic [1:0] {PH_IDLE, PH_REQ, PH_PER} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN, ST_RD, ST_CHK, ST_STAT_RD, ST_STAT_WR, ST_EMIT, ST_DRAIN
	} fsm_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [2:0]  target_job;
		logic        pass_done;
		logic        busy_res;
		logic [31:0] consec_errors;
		logic [31:0] job_runs;
		logic [31:0] job_errors;
		logic [31:0] job_duration;
		logic        last_of_run;
	} result_t;
endpackage
`default_nettype wire

### src/periodic_job_dispatcher.sv
// Periodic job dispatcher, top level: sequencer over per-job due and statistics memories.
// A status item goes through ST_EMIT into the result queue; a done item first does a statistics
// read-modify-write (ST_STAT_RD, ST_STAT_WR), then its pass goes on to scan the due entries
// (ST_SCAN, ST_RD, ST_CHK for each). Items are taken one at a time, each once the last
// result of the one before has left the queue. Reset restores control state and registers,
// then clears every entry of the memories (no item taken).
`default_nettype none
`include "periodic_job_dispatcher_defines.svh"
module periodic_job_dispatcher
	import pjd_pkg::*;
#(
	parameter int NUM_JOBS = 6
)(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [2:0]  job_id,
	input  wire logic [1:0]  error_class,
	input  wire logic [31:0] time_now,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       command,
	output logic [2:0]       target_job,
	output logic             pass_done,
	output logic             busy_res,
	output logic [31:0]      consec_errors,
	output logic [31:0]      job_runs,
	output logic [31:0]      job_errors,
	output logic [31:0]      job_duration,
	output logic             last_of_run
);
	localparam int AW = (NUM_JOBS > 1) ? $clog2(NUM_JOBS) : 1;

	// Configuration registers.
	logic [23:0] period_q [0:MAX_JOBS-1];
	logic [5:0]  enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q[0] <= PERIOD0_RST;
			period_q[1] <= PERIOD1_RST;
			period_q[2] <= PERIOD2_RST;
			period_q[3] <= PERIOD3_RST;
			period_q[4] <= PERIOD4_RST;
			period_q[5] <= PERIOD5_RST;
			enable_q    <= ENABLE_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_ENABLE) begin
				enable_q <= cfg_data[5:0];
			end else if (cfg_index < CFG_ENABLE) begin
				period_q[cfg_index] <= cfg_data;
			end
		end
	end

	// Memories: last due tick, and per-job {runs, errors}. Start tick and
	// duration of each job are kept in registers, so no memory keeps them.
	logic [31:0] due_mem   [0:NUM_JOBS-1];
	logic [63:0] stat_mem  [0:NUM_JOBS-1];
	logic [31:0] due_rd_s1;
	logic [63:0] stat_rd_s1;

	logic          due_we, stat_we;
	logic [AW-1:0] mem_addr;
	logic [31:0]   due_wd;
	logic [63:0]   stat_wd;

	always_ff @(posedge clk) begin
		if (due_we)  due_mem[mem_addr]  <= due_wd;
		if (stat_we) stat_mem[mem_addr] <= stat_wd;
		due_rd_s1  <= due_mem[mem_addr];
		stat_rd_s1 <= stat_mem[mem_addr];
	end

	// Sequencer state. now_q is the pass's current tick: the service tick,
	// then the tick of each done item.
	fsm_t         st_q, st_d;
	phase_t       phase_q;
	logic [5:0]   pend_q, preq_q;
	logic [2:0]   idx_q;
	logic [2:0]   run_q;
	logic [31:0]  dur_q, link_q, now_q;
	logic [1:0]   ecls_q;
	logic         clr_q;
	logic [AW:0]  clr_cnt_q;
	logic         periodic_q;
	result_t      emit_q;

	// Queue interface.
	logic         q_push, q_empty;
	result_t      q_data, q_out;

	pjd_out_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .push_data(q_data),
		.empty(q_empty), .pop_valid(out_valid), .pop_ready(out_ready), .pop_data(q_out)
	);

	assign command       = q_out.command;
	assign target_job    = q_out.target_job;
	assign pass_done     = q_out.pass_done;
	assign busy_res      = q_out.busy_res;
	assign consec_errors = q_out.consec_errors;
	assign job_runs      = q_out.job_runs;
	assign job_errors    = q_out.job_errors;
	assign job_duration  = q_out.job_duration;
	assign last_of_run   = q_out.last_of_run;

	// Accept only when idle, not clearing the memories, and the queue has drained, so a whole run fits.
	assign in_ready = (st_q == ST_IDLE) && q_empty && !clr_q;
	logic acc;
	assign acc = in_valid && in_ready;

	// Next requested job at or above idx_q.
	logic       req_hit;
	logic [2:0] req_j;
	always_comb begin
		req_hit = 1'b0;
		req_j   = '0;
		for (int j = MAX_JOBS - 1; j >= 0; j--) begin
			if (j < NUM_JOBS && preq_q[j] && 3'(j) >= idx_q) begin
				req_hit = 1'b1;
				req_j   = 3'(j);
			end
		end
	end

	// Wrapped time since the last due tick, from the registered due memory read.
	logic [31:0] elapsed;
	logic        due_ok;
	assign elapsed = now_q - due_rd_s1;
	assign due_ok  = enable_q[idx_q] && (period_q[idx_q] != 24'd0)
		&& (elapsed >= {8'd0, period_q[idx_q]});

	// Base status result with the current link count.
	function automatic result_t mk(input logic [1:0] c, input logic [2:0] t,
			input logic b, input logic [31:0] le);
		result_t r;
		r = '0;
		r.command = c;
		r.target_job = t;
		r.busy_res = b;
		r.consec_errors = le;
		return r;
	endfunction

	// Statistics update for a done item; class three counts as an other error.
	logic [31:0] link_n;
	logic [31:0] runs_n, errs_n;
	result_t     stat_res;
	assign runs_n = stat_rd_s1[63:32] + 32'd1;
	assign errs_n = stat_rd_s1[31:0] + {31'd0, ecls_q != ECLS_OK};
	always_comb begin
		link_n = link_q;
		if (ecls_q == ECLS_OK) link_n = '0;
		else if (ecls_q == ECLS_LINK && link_q != 32'hFFFF_FFFF) link_n = link_q + 32'd1;
	end

	always_comb begin
		stat_res              = mk(CMD_NONE, 3'd0, 1'b0, link_n);
		stat_res.job_runs     = runs_n;
		stat_res.job_errors   = errs_n;
		stat_res.job_duration = dur_q;
	end

	// Next state, memory strobes and queue pushes. The held result emit_q is
	// pushed whenever a newer one replaces it, and last with last_of_run.
	always_comb begin
		st_d     = st_q;
		q_push   = 1'b0;
		q_data   = emit_q;
		due_we   = 1'b0;
		stat_we  = 1'b0;
		due_wd   = now_q;
		stat_wd  = {runs_n, errs_n};
		mem_addr = idx_q[AW-1:0];
		if (clr_q) begin
			mem_addr = clr_cnt_q[AW-1:0];
			due_we   = 1'b1;
			stat_we  = 1'b1;
			due_wd   = '0;
			stat_wd  = '0;
		end
		case (st_q)
			ST_IDLE: begin
				if (acc) begin
					if (kind == KIND_SERVICE && phase_q == PH_IDLE) st_d = ST_SCAN;
					else if (kind == KIND_DONE && phase_q != PH_IDLE) st_d = ST_STAT_RD;
					else st_d = ST_EMIT;
				end
			end
			ST_SCAN: begin
				if (phase_q == PH_REQ && req_hit) begin
					// Push the held result, start the requested job.
					q_push = 1'b1;
					st_d   = ST_EMIT;
				end else if (phase_q == PH_PER && 32'(idx_q) < 32'(NUM_JOBS)) begin
					st_d = ST_RD;
				end else if (phase_q == PH_REQ) begin
					st_d = ST_SCAN;
				end else begin
					// Pass over: the held result closes it.
					q_push = 1'b1;
					q_data.pass_done = 1'b1;
					q_data.last_of_run = 1'b1;
					st_d = ST_IDLE;
				end
			end
			ST_RD: st_d = ST_CHK;
			ST_CHK: begin
				if (due_ok) begin
					due_we = 1'b1;
					q_push = 1'b1;
					st_d   = ST_EMIT;
				end else begin
					st_d = ST_SCAN;
				end
			end
			ST_STAT_RD: begin
				mem_addr = run_q[AW-1:0];
				st_d     = ST_STAT_WR;
			end
			ST_STAT_WR: begin
				mem_addr = run_q[AW-1:0];
				stat_we  = 1'b1;
				// A periodic job 0 or 1 is followed by a drain command.
				if (periodic_q && (run_q == 3'd0 || run_q == 3'd1)) st_d = ST_DRAIN;
				else st_d = ST_SCAN;
			end
			ST_DRAIN: begin
				q_push = 1'b1;
				st_d   = ST_SCAN;
			end
			ST_EMIT: begin
				q_push = 1'b1;
				q_data.last_of_run = 1'b1;
				st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else         st_q <= st_d;
	end

	// Held result and pass bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			pend_q    <= '0;
			preq_q    <= '0;
			idx_q     <= '0;
			run_q     <= '0;
			dur_q     <= '0;
			link_q    <= '0;
			now_q     <= '0;
			ecls_q    <= '0;
			periodic_q <= 1'b0;
			emit_q    <= '0;
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + (AW+1)'(1);
				if (32'(clr_cnt_q) == 32'(NUM_JOBS - 1)) clr_q <= 1'b0;
			end
			if (acc) begin
				if (kind == KIND_SERVICE && phase_q == PH_IDLE) begin
					now_q   <= time_now;
					emit_q  <= mk(CMD_DRAIN, 3'd0, 1'b0, link_q);
					preq_q  <= pend_q;
					pend_q  <= '0;
					phase_q <= PH_REQ;
					idx_q   <= '0;
				end else if (kind == KIND_DONE && phase_q != PH_IDLE) begin
					ecls_q     <= error_class;
					dur_q      <= time_now - now_q;
					now_q      <= time_now;
					periodic_q <= phase_q == PH_PER;
				end else begin
					if (kind == KIND_REQUEST && 32'(job_id) < 32'(NUM_JOBS))
						pend_q[job_id] <= 1'b1;
					if (kind == KIND_CLEAR) link_q <= '0;
					emit_q <= mk(CMD_NONE, 3'd0, phase_q != PH_IDLE,
						(kind == KIND_CLEAR) ? 32'd0 : link_q);
				end
			end
			case (st_q)
				ST_STAT_WR: begin
					link_q <= link_n;
					emit_q <= stat_res;
				end
				ST_DRAIN: begin
					emit_q <= mk(CMD_DRAIN, 3'd0, 1'b0, link_q);
				end
				ST_SCAN: begin
					if (phase_q == PH_REQ && req_hit) begin
						preq_q[req_j] <= 1'b0;
						run_q  <= req_j;
						idx_q  <= req_j + 3'd1;
						emit_q <= mk(CMD_START, req_j, 1'b1, link_q);
					end else if (phase_q == PH_REQ) begin
						phase_q <= PH_PER;
						idx_q   <= '0;
					end else if (!(phase_q == PH_PER && 32'(idx_q) < 32'(NUM_JOBS))) begin
						phase_q <= PH_IDLE;
						idx_q   <= '0;
						preq_q  <= '0;
					end
				end
				ST_CHK: begin
					if (due_ok) begin
						run_q  <= idx_q;
						emit_q <= mk(CMD_START, idx_q, 1'b1, link_q);
					end
					idx_q <= idx_q + 3'd1;
				end
				default: ;
			endcase
		end
	end

	`PJD_ASSERT_IMP(a_accept_idle, clk, arst_n, acc, q_empty,
		"item accepted with results still queued")
	`PJD_ASSERT_NXT(a_busy_start, clk, arst_n, st_q == ST_CHK && due_ok,
		phase_q == PH_PER, "periodic start outside periodic phase")
	`PJD_ASSERT_IMP(a_no_acc_clear, clk, arst_n, clr_q, !in_ready,
		"item accepted during memory clear")
endmodule
`default_nettype wire

### src/pjd_out_queue.sv
// Four-entry result queue between the sequencer and the output channel.
// Depends on pjd_pkg.
`default_nettype none
module pjd_out_queue
	import pjd_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  result_t      push_data,
	output logic         empty,
	output logic         pop_valid,
	input  wire logic    pop_ready,
	output result_t      pop_data
);
	result_t     mem_q [0:3];
	logic [1:0]  wr_q, rd_q;
	logic [2:0]  cnt_q;
	logic        pop;

	assign pop       = pop_valid && pop_ready;
	assign pop_valid = cnt_q != 3'd0;
	assign empty     = cnt_q == 3'd0;
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop)  rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end
endmodule
`default_nettype wire
